// ===== hdl/slc_pkg.sv =====
// Shared types and constants for the slope-compare line rasterizer.
// No dependencies; imported by every module of the block.
package slc_pkg;

	localparam int COORD_BITS  = 13;
	// |ay*dx - dy*ax| stays below 2^(2*COORD_BITS+1)
	localparam int ERR_BITS    = 2 * COORD_BITS + 2;
	localparam int DELTA_BITS  = COORD_BITS + 1;
	localparam int DIM_BITS    = 13;
	localparam int STRIDE_BITS = 16;
	localparam int BPP_BITS    = 6;
	localparam int OFFSET_BITS = 28;
	localparam int COLOR_BITS  = 32;
	localparam int STATUS_BITS = 3;

	localparam int CFG_DATA_BITS = 16;
	localparam int CFG_IDX_BITS  = 2;

	localparam int IN_FIELD_BITS  = 4 * COORD_BITS + COLOR_BITS;
	localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
	localparam int OUT_FIELD_BITS = 2 * COORD_BITS + OFFSET_BITS + COLOR_BITS;
	localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

	localparam logic [DIM_BITS-1:0]    RST_WIDTH  = DIM_BITS'(1920);
	localparam logic [DIM_BITS-1:0]    RST_HEIGHT = DIM_BITS'(1080);
	localparam logic [STRIDE_BITS-1:0] RST_STRIDE = STRIDE_BITS'(7680);
	localparam logic [BPP_BITS-1:0]    RST_BPP    = BPP_BITS'(32);

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_WRITTEN = 3'd0,
		ST_CLIPPED = 3'd1,
		ST_ACCEPT  = 3'd2,
		ST_REJECT  = 3'd3,
		ST_IDLE    = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_STRIDE = 2'd2,
		CFG_BPP    = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		DIR_FLAT = 2'd0,
		DIR_FALL = 2'd1,
		DIR_RISE = 2'd2
	} dir_t;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		status_t                 status;
		coord_t                  x;
		coord_t                  y;
		logic [COLOR_BITS-1:0]   color;
		logic                    last;
	} pix_t;

	typedef struct packed {
		logic [DIM_BITS-1:0]    width;
		logic [DIM_BITS-1:0]    height;
		logic [STRIDE_BITS-1:0] stride;
		logic [BPP_BITS-1:0]    bpp;
	} cfg_t;

endpackage

// ===== hdl/slope_compare_line_rasterizer.sv =====
// Line rasterizer: a load beat (tuser 0) takes a segment, each step beat (tuser 1) returns
// one pixel with its frame-buffer byte offset. One beat is accepted every clock unless the output
// stalls; each result passes through the stepper result register and then the offset register.
// The step choice uses a running error term updated by one add.
module slope_compare_line_rasterizer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [slc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [slc_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// x_start, y_start, x_end, y_end, color, zero pad
	input  logic [slc_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
	// cmd
	input  logic                              s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// pixel_x, pixel_y, byte_offset, pixel_value, zero pad
	output logic [slc_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
	// status
	output logic [slc_pkg::STATUS_BITS-1:0]   m_axis_tuser,
	output logic                              m_axis_tlast
);
	import slc_pkg::*;

	cfg_t                   cfg_q;
	logic                   pix_valid, pix_ready;
	pix_t                   pix, out_pix;
	logic [OFFSET_BITS-1:0] out_offset;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= RST_WIDTH;
			cfg_q.height <= RST_HEIGHT;
			cfg_q.stride <= RST_STRIDE;
			cfg_q.bpp    <= RST_BPP;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_WIDTH:  cfg_q.width  <= cfg_data[DIM_BITS-1:0];
				CFG_HEIGHT: cfg_q.height <= cfg_data[DIM_BITS-1:0];
				CFG_STRIDE: cfg_q.stride <= cfg_data[STRIDE_BITS-1:0];
				CFG_BPP:    cfg_q.bpp    <= cfg_data[BPP_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	slc_stepper u_stepper (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.cmd       (s_axis_tuser),
		.x_start   (coord_t'(s_axis_tdata[COORD_BITS-1:0])),
		.y_start   (coord_t'(s_axis_tdata[2*COORD_BITS-1:COORD_BITS])),
		.x_end     (coord_t'(s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS])),
		.y_end     (coord_t'(s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS])),
		.color     (s_axis_tdata[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS]),
		.cfg       (cfg_q),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix)
	);

	slc_addr u_addr (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_ready  (pix_ready),
		.pix        (pix),
		.cfg        (cfg_q),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_pix    (out_pix),
		.out_offset (out_offset)
	);

	assign m_axis_tdata = {(OUT_DATA_BITS - OUT_FIELD_BITS)'(0), out_pix.color, out_offset,
	                       out_pix.y, out_pix.x};
	assign m_axis_tuser = out_pix.status;
	assign m_axis_tlast = out_pix.last;

	// empty output stage always frees the input side
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with output stage empty");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (out_pix.status != ST_WRITTEN) |-> (out_offset == '0))
		else $error("byte offset on a beat that writes no pixel");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |->
			(out_pix.status == ST_WRITTEN) || (out_pix.status == ST_CLIPPED))
		else $error("last flag on a non-pixel beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && ((pix.status == ST_ACCEPT) || (pix.status == ST_REJECT) ||
		(pix.status == ST_IDLE)) |-> (pix.x == '0) && (pix.y == '0) && (pix.color == '0))
		else $error("pixel fields set on a non-pixel beat");

endmodule

// ===== hdl/slc_stepper.sv =====
// Segment state and one-pixel-per-beat stepping with an incremental error term.
// Depends on slc_pkg; feeds slc_addr through a registered result stage.
module slc_stepper (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           cmd,
	input  slc_pkg::coord_t                x_start,
	input  slc_pkg::coord_t                y_start,
	input  slc_pkg::coord_t                x_end,
	input  slc_pkg::coord_t                y_end,
	input  logic [slc_pkg::COLOR_BITS-1:0] color,
	input  slc_pkg::cfg_t                  cfg,
	output logic                           pix_valid,
	input  logic                           pix_ready,
	output slc_pkg::pix_t                  pix
);
	import slc_pkg::*;

	coord_t                        col_q, row_q, tcol_q, trow_q;
	logic signed [DELTA_BITS-1:0]  dx_q, dy_q;
	logic signed [ERR_BITS-1:0]    err_q;
	logic [COLOR_BITS-1:0]         color_q;
	dir_t                          dir_q;
	logic                          active_q, first_q;

	pix_t                          pix_s1;
	logic                          valid_s1;

	logic                          accept;
	logic                          ld_reject;
	dir_t                          ld_dir;
	logic signed [DELTA_BITS-1:0]  ld_dx, ld_dy;
	logic signed [ERR_BITS-1:0]    dx_e, dy_e;
	coord_t                        col_n, row_n;
	logic signed [ERR_BITS-1:0]    err_n;
	logic                          is_last, in_win;
	pix_t                          pix_n;

	assign accept   = in_valid && in_ready;
	assign in_ready = !valid_s1 || pix_ready;

	assign ld_dx     = DELTA_BITS'(x_end) - DELTA_BITS'(x_start);
	assign ld_dy     = DELTA_BITS'(y_end) - DELTA_BITS'(y_start);
	assign ld_reject = (x_end <= x_start);
	assign ld_dir    = (y_end < y_start) ? DIR_FALL :
	                   (y_end > y_start) ? DIR_RISE : DIR_FLAT;

	assign dx_e = ERR_BITS'(dx_q);
	assign dy_e = ERR_BITS'(dy_q);

	// err = ay*dx - dy*ax, updated by one add per step
	always_comb begin
		col_n = col_q;
		row_n = row_q;
		err_n = err_q;
		if (first_q) begin
			col_n = coord_t'(col_q + coord_t'(1));
			if (dir_q == DIR_RISE) begin
				row_n = coord_t'(row_q + coord_t'(1));
				err_n = dx_e - dy_e;
			end else begin
				err_n = -dy_e;
			end
		end else begin
			case (dir_q)
				DIR_RISE: begin
					if (!err_q[ERR_BITS-1]) begin
						col_n = coord_t'(col_q + coord_t'(1));
						err_n = err_q - dy_e;
					end else begin
						row_n = coord_t'(row_q + coord_t'(1));
						err_n = err_q + dx_e;
					end
				end
				DIR_FALL: begin
					if (err_q <= 0) begin
						col_n = coord_t'(col_q + coord_t'(1));
						err_n = err_q - dy_e;
					end else begin
						row_n = coord_t'(row_q - coord_t'(1));
						err_n = err_q - dx_e;
					end
				end
				default: begin
					col_n = coord_t'(col_q + coord_t'(1));
				end
			endcase
		end
	end

	assign is_last = (col_n == tcol_q) && (row_n == trow_q);
	assign in_win  = !col_n[COORD_BITS-1] && !row_n[COORD_BITS-1] &&
	                 (DIM_BITS'(col_n[COORD_BITS-2:0]) < cfg.width) &&
	                 (DIM_BITS'(row_n[COORD_BITS-2:0]) < cfg.height);

	always_comb begin
		pix_n = '0;
		if (cmd == CMD_LOAD) begin
			pix_n.status = ld_reject ? ST_REJECT : ST_ACCEPT;
		end else if (!active_q) begin
			pix_n.status = ST_IDLE;
		end else begin
			pix_n.status = in_win ? ST_WRITTEN : ST_CLIPPED;
			pix_n.x      = col_n;
			pix_n.y      = row_n;
			pix_n.color  = color_q;
			pix_n.last   = is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			first_q  <= 1'b0;
			dir_q    <= DIR_FLAT;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (pix_ready) begin
				valid_s1 <= 1'b0;
			end
			if (accept && (cmd == CMD_LOAD)) begin
				active_q <= !ld_reject;
				first_q  <= !ld_reject;
				if (!ld_reject) begin
					dir_q <= ld_dir;
				end
			end else if (accept && active_q) begin
				first_q <= 1'b0;
				if (is_last) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pix_n;
			if ((cmd == CMD_LOAD) && !ld_reject) begin
				col_q   <= x_start;
				row_q   <= y_start;
				tcol_q  <= x_end;
				trow_q  <= y_end;
				dx_q    <= ld_dx;
				dy_q    <= ld_dy;
				err_q   <= '0;
				color_q <= color;
			end else if ((cmd == CMD_STEP) && active_q) begin
				col_q <= col_n;
				row_q <= row_n;
				err_q <= err_n;
			end
		end
	end

	assign pix_valid = valid_s1;
	assign pix       = pix_s1;

endmodule

// ===== hdl/slc_addr.sv =====
// Frame-buffer byte offset stage and output register.
// Depends on slc_pkg; takes pixel results from slc_stepper.
module slc_addr (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pix_valid,
	output logic                            pix_ready,
	input  slc_pkg::pix_t                   pix,
	input  slc_pkg::cfg_t                   cfg,
	output logic                            out_valid,
	input  logic                            out_ready,
	output slc_pkg::pix_t                   out_pix,
	output logic [slc_pkg::OFFSET_BITS-1:0] out_offset
);
	import slc_pkg::*;

	localparam int ROW_PROD_BITS = COORD_BITS - 1 + STRIDE_BITS;
	localparam int COL_PROD_BITS = COORD_BITS - 1 + BPP_BITS - 3;

	logic [ROW_PROD_BITS-1:0] row_prod;
	logic [COL_PROD_BITS-1:0] col_prod;
	logic [OFFSET_BITS-1:0]   offset_n;

	pix_t                     pix_s2;
	logic [OFFSET_BITS-1:0]   offset_s2;
	logic                     valid_s2;

	assign pix_ready = !valid_s2 || out_ready;

	// coordinates are non-negative whenever the pixel is written
	assign row_prod = ROW_PROD_BITS'(pix.y[COORD_BITS-2:0]) * ROW_PROD_BITS'(cfg.stride);
	assign col_prod = COL_PROD_BITS'(pix.x[COORD_BITS-2:0]) *
	                  COL_PROD_BITS'(cfg.bpp[BPP_BITS-1:3]);
	assign offset_n = (pix.status == ST_WRITTEN) ?
	                  OFFSET_BITS'(ROW_PROD_BITS'(row_prod + ROW_PROD_BITS'(col_prod))) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (pix_ready) begin
			valid_s2 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_valid && pix_ready) begin
			pix_s2    <= pix;
			offset_s2 <= offset_n;
		end
	end

	assign out_valid  = valid_s2;
	assign out_pix    = pix_s2;
	assign out_offset = offset_s2;

endmodule

// ===== sim/slope_compare_line_rasterizer_tb.sv =====
// Testbench for slope_compare_line_rasterizer: a directed table, then random segments,
// checked beat by beat against an in-bench line-stepping predictor over several windows.
// Depends on hdl/slc_pkg.sv and the rasterizer RTL.
`timescale 1ns / 100ps

module slope_compare_line_rasterizer_tb;
	import slc_pkg::*;

	typedef struct packed {
		status_t                status;
		coord_t                 x;
		coord_t                 y;
		logic [OFFSET_BITS-1:0] offset;
		logic [COLOR_BITS-1:0]  value;
		logic                   last;
	} raster_px_t;

	typedef struct packed {
		bit      chk;
		status_t want;
	} beat_note_t;

	typedef struct {
		logic        cmd;
		int          xs, ys, xe, ye;
		logic [31:0] color;
		bit          chk;
		status_t     want;
	} stim_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	logic                     s_axis_tvalid;
	logic                     s_axis_tready;
	logic [IN_DATA_BITS-1:0]  s_axis_tdata;
	logic                     s_axis_tuser;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready;
	logic [OUT_DATA_BITS-1:0] m_axis_tdata;
	logic [STATUS_BITS-1:0]   m_axis_tuser;
	logic                     m_axis_tlast;

	slope_compare_line_rasterizer uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	// predictor state, reset values
	logic [DIM_BITS-1:0]    win_w     = 13'd1920;
	logic [DIM_BITS-1:0]    win_h     = 13'd1080;
	logic [STRIDE_BITS-1:0] row_pitch = 16'd7680;
	logic [BPP_BITS-1:0]    pix_bits  = 6'd32;
	longint                 pen_x = 0, pen_y = 0, from_x = 0, from_y = 0, to_x = 0, to_y = 0;
	logic [COLOR_BITS-1:0]  line_color = '0;
	dir_t                   slope_dir = DIR_FLAT;
	bit                     drawing = 0;
	bit                     fresh_seg = 0;

	raster_px_t pending_pixels [$];
	beat_note_t beat_notes [$];
	int         fail_count = 0;
	int         results_seen = 0;
	int         beats_sent = 0;

	stim_row_t plan [25] = '{
		'{CMD_STEP,     0,     0,     0,     0, 32'h0000_0000, 1'b1, ST_IDLE},
		'{CMD_LOAD,     0,     0,     0,     5, 32'h1111_1111, 1'b1, ST_REJECT},
		'{CMD_LOAD,     7,     7,     7,     7, 32'h2222_2222, 1'b1, ST_REJECT},
		'{CMD_LOAD,  4095, -4096, -4096,  4095, 32'hFFFF_FFFF, 1'b1, ST_REJECT},
		'{CMD_LOAD, -4096, -4096,  4095,  4095, 32'hFFFF_FFFF, 1'b1, ST_ACCEPT},
		'{CMD_STEP,     0,     0,     0,     0, 32'h0000_0000, 1'b0, ST_WRITTEN},
		'{CMD_STEP,     0,     0,     0,     0, 32'h0000_0000, 1'b0, ST_WRITTEN},
		'{CMD_LOAD,   100,    50,    99,    50, 32'h3333_3333, 1'b1, ST_REJECT},
		'{CMD_STEP,     0,     0,     0,     0, 32'h0000_0000, 1'b1, ST_IDLE},
		'{CMD_LOAD,     5,     5,     6,     5, 32'h0000_0000, 1'b1, ST_ACCEPT},
		'{CMD_STEP,     0,     0,     0,     0, 32'h0000_0000, 1'b0, ST_WRITTEN},
		'{CMD_STEP,     0,     0,     0,     0, 32'h0000_0000, 1'b1, ST_IDLE},
		'{CMD_LOAD,     0,     3,     3,     0, 32'hA5A5_A5A5, 1'b1, ST_ACCEPT},
		'{CMD_STEP,     0,     0,     0,     0, 32'h0000_0000, 1'b0, ST_WRITTEN},
		'{CMD_STEP,     0,     0,     0,     0, 32'h0000_0000, 1'b0, ST_WRITTEN},
		'{CMD_STEP,     0,     0,     0,     0, 32'h0000_0000, 1'b0, ST_WRITTEN},
		'{CMD_STEP,     0,     0,     0,     0, 32'h0000_0000, 1'b0, ST_WRITTEN},
		'{CMD_STEP,     0,     0,     0,     0, 32'h0000_0000, 1'b0, ST_WRITTEN},
		'{CMD_STEP,     0,     0,     0,     0, 32'h0000_0000, 1'b0, ST_WRITTEN},
		'{CMD_LOAD,  1918,  1078,  1920,  1080, 32'h5A5A_5A5A, 1'b1, ST_ACCEPT},
		'{CMD_STEP,     0,     0,     0,     0, 32'h0000_0000, 1'b0, ST_WRITTEN},
		'{CMD_STEP,     0,     0,     0,     0, 32'h0000_0000, 1'b0, ST_WRITTEN},
		'{CMD_LOAD,  4094,  4095,  4095, -4096, 32'hC3C3_C3C3, 1'b1, ST_ACCEPT},
		'{CMD_STEP,     0,     0,     0,     0, 32'h0000_0000, 1'b0, ST_WRITTEN},
		'{CMD_STEP,     0,     0,     0,     0, 32'h0000_0000, 1'b0, ST_WRITTEN}
	};

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic raster_px_t rasterize_step(input logic cmd,
			input logic [IN_DATA_BITS-1:0] d);
		raster_px_t px;
		longint     xs, ys, xe, ye, dx, dy, ax, ay, lhs, rhs, off;
		bit         hit_end, in_win;
		px = '0;
		if (cmd == CMD_LOAD) begin
			xs = longint'($signed(d[12:0]));
			ys = longint'($signed(d[25:13]));
			xe = longint'($signed(d[38:26]));
			ye = longint'($signed(d[51:39]));
			if (xe - xs <= 0) begin
				drawing = 0;
				fresh_seg = 0;
				px.status = ST_REJECT;
				return px;
			end
			from_x = xs;
			from_y = ys;
			to_x = xe;
			to_y = ye;
			pen_x = xs;
			pen_y = ys;
			line_color = d[83:52];
			if (ye < ys)
				slope_dir = DIR_FALL;
			else if (ye > ys)
				slope_dir = DIR_RISE;
			else
				slope_dir = DIR_FLAT;
			drawing = 1;
			fresh_seg = 1;
			px.status = ST_ACCEPT;
			return px;
		end
		if (!drawing) begin
			px.status = ST_IDLE;
			return px;
		end
		if (fresh_seg) begin
			pen_x++;
			if (slope_dir == DIR_RISE)
				pen_y++;
			fresh_seg = 0;
		end else begin
			dx = to_x - from_x;
			dy = to_y - from_y;
			ax = pen_x - from_x;
			ay = pen_y - from_y;
			lhs = ay * dx;
			rhs = dy * ax;
			case (slope_dir)
				DIR_FALL: begin
					if (lhs <= rhs)
						pen_x++;
					else
						pen_y--;
				end
				DIR_RISE: begin
					if (lhs >= rhs)
						pen_x++;
					else
						pen_y++;
				end
				default: pen_x++;
			endcase
		end
		hit_end = (pen_x == to_x) && (pen_y == to_y);
		in_win = pen_x >= 0 && pen_x < longint'(win_w) && pen_y >= 0 && pen_y < longint'(win_h);
		if (hit_end)
			drawing = 0;
		px.x = coord_t'(pen_x[12:0]);
		px.y = coord_t'(pen_y[12:0]);
		px.value = line_color;
		px.last = hit_end;
		if (in_win) begin
			off = pen_y * longint'(row_pitch) + pen_x * longint'(pix_bits >> 3);
			px.status = ST_WRITTEN;
			px.offset = off[OFFSET_BITS-1:0];
		end else begin
			px.status = ST_CLIPPED;
		end
		return px;
	endfunction

	function automatic void field_check(input string what, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : monitor
		raster_px_t want, got, pred;
		beat_note_t note;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				note = (beat_notes.size() != 0) ? beat_notes.pop_front() : '0;
				pred = rasterize_step(s_axis_tuser, s_axis_tdata);
				if (note.chk) begin
					pred = '0;
					pred.status = note.want;
				end
				pending_pixels.push_back(pred);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				got.status = status_t'(m_axis_tuser);
				got.x = coord_t'(m_axis_tdata[12:0]);
				got.y = coord_t'(m_axis_tdata[25:13]);
				got.offset = m_axis_tdata[53:26];
				got.value = m_axis_tdata[85:54];
				got.last = m_axis_tlast;
				if (pending_pixels.size() == 0) begin
					$display("%0t: unexpected result beat, status %0d", $time, m_axis_tuser);
					fail_count++;
				end else begin
					want = pending_pixels.pop_front();
					field_check("status", want.status, got.status);
					field_check("pixel_x", want.x, got.x);
					field_check("pixel_y", want.y, got.y);
					field_check("byte_offset", want.offset, got.offset);
					field_check("pixel_value", want.value, got.value);
					field_check("last", want.last, got.last);
				end
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (beats_sent % 100 < 25)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int full_coord();
		return int'($urandom_range(0, 8191)) - 4096;
	endfunction

	function automatic logic [IN_DATA_BITS-1:0] pack_seg(input int xs, input int ys,
			input int xe, input int ye, input logic [31:0] color);
		return {{(IN_DATA_BITS - IN_FIELD_BITS){1'b0}}, color,
			coord_t'(ye), coord_t'(xe), coord_t'(ys), coord_t'(xs)};
	endfunction

	task automatic send_beat(input logic cmd, input logic [IN_DATA_BITS-1:0] data,
			input bit chk, input status_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= data;
		beat_notes.push_back('{chk, want});
		beats_sent++;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic send_step();
		send_beat(CMD_STEP, pack_seg(full_coord(), full_coord(), full_coord(), full_coord(),
			$urandom()), 1'b0, ST_WRITTEN);
	endtask

	task automatic send_load(input int xs, input int ys, input int xe, input int ye);
		send_beat(CMD_LOAD, pack_seg(xs, ys, xe, ye, $urandom()), 1'b0, ST_WRITTEN);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_BITS-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_WIDTH:  win_w = val[DIM_BITS-1:0];
			CFG_HEIGHT: win_h = val[DIM_BITS-1:0];
			CFG_STRIDE: row_pitch = val[STRIDE_BITS-1:0];
			CFG_BPP:    pix_bits = val[BPP_BITS-1:0];
			default: begin
			end
		endcase
	endtask

	task automatic program_regs(input logic [15:0] w, input logic [15:0] h,
			input logic [15:0] s, input logic [15:0] b);
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_HEIGHT, h);
		write_reg(CFG_STRIDE, s);
		write_reg(CFG_BPP, b);
		cfg_we <= 1'b0;
	endtask

	// mostly whole segments near the window, some partial (replaced), some rejects and strays
	task automatic random_phase(input int quota);
		int stop, r, xs, ys, xe, ye, dx, dy, len, steps, lim_x, lim_y;
		stop = beats_sent + quota;
		lim_x = (int'(win_w) > 4000) ? 4000 : int'(win_w) + 16;
		lim_y = (int'(win_h) > 4000) ? 4000 : int'(win_h) + 16;
		while (beats_sent < stop) begin
			r = $urandom_range(0, 99);
			if (r < 6) begin
				send_step();
			end else if (r < 16) begin
				xs = full_coord();
				if ($urandom_range(0, 1))
					xe = int'($urandom_range(0, xs + 4096)) - 4096;
				else
					xe = (xs - int'($urandom_range(0, 4)) < -4096) ? -4096 :
						xs - int'($urandom_range(0, 4));
				send_load(xs, full_coord(), xe, full_coord());
			end else begin
				if (r < 26) begin
					xs = full_coord();
					ys = full_coord();
				end else begin
					xs = int'($urandom_range(0, lim_x)) - 8;
					ys = int'($urandom_range(0, lim_y)) - 8;
				end
				if (r == 99) begin
					dx = $urandom_range(1, 100);
					dy = int'($urandom_range(0, 200)) - 100;
				end else begin
					dx = $urandom_range(1, 12);
					dy = int'($urandom_range(0, 24)) - 12;
				end
				xe = (xs + dx > 4095) ? 4095 : xs + dx;
				ye = ys + dy;
				if (ye > 4095)
					ye = 4095;
				if (ye < -4096)
					ye = -4096;
				send_load(xs, ys, xe, ye);
				len = (xe - xs) + ((ye > ys) ? ye - ys : ys - ye);
				if (len > 220)
					len = 220;
				steps = len + int'($urandom_range(0, 2));
				if ($urandom_range(0, 9) == 0)
					steps = $urandom_range(0, len);
				repeat (steps)
					send_step();
			end
		end
	endtask

	initial begin : sink
		int  r, n;
		bit  held;
		held = 0;
		m_axis_tready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (!held && results_seen >= 300) begin
				held = 1;
				m_axis_tready <= 1'b0;
				n = 250;
			end else if (r < 55) begin
				m_axis_tready <= 1'b1;
				n = $urandom_range(1, 8);
			end else if (r < 65) begin
				m_axis_tready <= 1'b1;
				n = $urandom_range(30, 80);
			end else if (r < 95) begin
				m_axis_tready <= 1'b0;
				n = $urandom_range(1, 3);
			end else begin
				m_axis_tready <= 1'b0;
				n = $urandom_range(10, 60);
			end
			repeat (n) @(posedge clk);
		end
	end

	initial begin : stim
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_WIDTH;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser = CMD_LOAD;
		s_axis_tdata = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send_beat(plan[i].cmd, pack_seg(plan[i].xs, plan[i].ys, plan[i].xe, plan[i].ye,
				plan[i].color), plan[i].chk, plan[i].want);
		random_phase(100);
		drain();
		program_regs(16'd64, 16'd48, 16'd256, 16'd8);
		random_phase(110);
		drain();
		program_regs(16'd1, 16'd1, 16'd1, 16'd7);
		random_phase(90);
		drain();
		program_regs(16'd4096, 16'd4096, 16'd65535, 16'd32);
		random_phase(110);
		drain();
		// zero window clips everything; upper data bits are dropped by the bpp register
		program_regs(16'd0, 16'd0, 16'd0, 16'hFFC0);
		random_phase(80);
		drain();
		program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd63);
		random_phase(110);
		drain();
		program_regs(16'($urandom_range(0, 8191)), 16'($urandom_range(0, 8191)),
			16'($urandom_range(1, 65535)), 16'($urandom_range(8, 32)));
		random_phase(60);
		drain();

		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin : watchdog
		#(64'd20_000_000);
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/slc_pkg.sv
hdl/slc_stepper.sv
hdl/slc_addr.sv
hdl/slope_compare_line_rasterizer.sv
sim/slope_compare_line_rasterizer_tb.sv
